>>> rtl/crcl_pkg.sv
`default_nettype none

package crcl_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_CMD  = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_RX     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Reply status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OK       = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  // Work handed from front to back; a frame end expands into four beats
  typedef enum logic [1:0] {
    JOB_TX_BYTE  = 2'd0,
    JOB_TX_FRAME = 2'd1,
    JOB_RX_BYTE  = 2'd2,
    JOB_TIMEOUT  = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic        fin;
    status_t     status;
  } job_t;

  localparam logic [15:0] CRC_START     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  END_MARK      = 8'hC1;
  localparam logic [7:0]  ESC_MARK      = 8'hFE;
  localparam logic [17:0] TIMEOUT_RESET = 18'd200000;
  localparam logic [17:0] TICKS_MAX     = 18'h3FFFF;
  localparam logic [1:0]  POS_MAX       = 2'd3;

  // Shift one byte, MSB first, into the CRC register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] crc;
    logic        top;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      top = crc[15];
      crc = {crc[14:0], data[7-i]};
      if (top) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc_framed_command_link_core.sv
`default_nettype none

// Framed command link with CRC-16 trailer and escaped reply parsing. Command
// bytes (action 0) go out unchanged; the byte flagged last_byte also releases
// CRC low, CRC high and the 0xC1 trailer, after which the link waits for a
// reply (action 1) or counts ticks (action 2) up to the timeout register.
// Input beats are taken one per cycle as long as the job queue between the
// classifier and the output sequencer has room (QUEUE_DEPTH jobs). Results
// leave one beat per cycle while out_stall is low, from a registered output
// stage; a frame end expands into four beats and every other result into one,
// so a steady stream of frame ends is bound by the output side. The timeout
// register resets to 200000; the user must write it through cfg_wr_en /
// cfg_wr_data only while the link is idle; the block does not enforce this.
module crc_framed_command_link_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             out_end_of_run,
  output logic [1:0]       out_status,
  input  wire logic        cfg_wr_en,
  input  wire logic [17:0] cfg_wr_data
);
  import crcl_pkg::*;

  logic full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign in_stall = full;

  crcl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_valid && !full),
    .action      (in_action),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .job         (push_job)
  );

  crcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  crcl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/crcl_front.sv
`default_nettype none

module crcl_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic               cfg_wr_en,
  input  wire logic [17:0]        cfg_wr_data,
  output logic                    push,
  output crcl_pkg::job_t          job
);
  import crcl_pkg::*;

  logic [17:0] limit_r;
  logic [15:0] crc_r,        crc_nxt;
  logic [1:0]  tx_pos_r,     tx_pos_nxt;
  logic [7:0]  sent_first_r, sent_first_nxt;
  logic [7:0]  sent_second_r, sent_second_nxt;
  logic [1:0]  rx_pos_r,     rx_pos_nxt;
  logic [7:0]  got_first_r,  got_first_nxt;
  logic [7:0]  got_second_r, got_second_nxt;
  logic        esc_r,        esc_nxt;
  logic        awaiting_r,   awaiting_nxt;
  logic [17:0] wait_r,       wait_nxt;

  // Classify the beat and update the link state
  always_comb begin
    logic [15:0] crc_new;
    logic [7:0]  tb [4];
    logic [1:0]  pos;
    logic [7:0]  sf;
    logic [7:0]  ss;
    logic        ends;
    logic [17:0] ticks;

    crc_nxt         = crc_r;
    tx_pos_nxt      = tx_pos_r;
    sent_first_nxt  = sent_first_r;
    sent_second_nxt = sent_second_r;
    rx_pos_nxt      = rx_pos_r;
    got_first_nxt   = got_first_r;
    got_second_nxt  = got_second_r;
    esc_nxt         = esc_r;
    awaiting_nxt    = awaiting_r;
    wait_nxt        = wait_r;
    push            = 1'b0;
    job             = '0;

    crc_new = (tx_pos_r != 2'd0) ? crc_byte(crc_r, data_byte) : crc_r;
    tb[0]   = data_byte;
    tb[1]   = crc_new[7:0];
    tb[2]   = crc_new[15:8];
    tb[3]   = END_MARK;
    pos     = tx_pos_r;
    sf      = sent_first_r;
    ss      = sent_second_r;
    ends    = !esc_r && (data_byte == END_MARK);
    ticks   = (wait_r == TICKS_MAX) ? wait_r : wait_r + 18'd1;

    if (accept) begin
      unique case (action_t'(action))
        ACT_CMD: begin
          if (!awaiting_r) begin
            // track header bytes over every byte that goes out
            for (int i = 0; i < 4; i++) begin
              if (i == 0 || last_byte) begin
                if (pos == 2'd1) begin
                  sf = tb[i];
                end else if (pos == 2'd2) begin
                  ss = tb[i];
                end
                if (pos != POS_MAX) begin
                  pos = pos + 2'd1;
                end
              end
            end
            sent_first_nxt  = sf;
            sent_second_nxt = ss;
            push     = 1'b1;
            job.kind = last_byte ? JOB_TX_FRAME : JOB_TX_BYTE;
            job.data = data_byte;
            job.crc  = crc_new;
            if (last_byte) begin
              tx_pos_nxt     = 2'd0;
              crc_nxt        = CRC_START;
              awaiting_nxt   = 1'b1;
              wait_nxt       = '0;
              rx_pos_nxt     = 2'd0;
              got_first_nxt  = '0;
              got_second_nxt = '0;
              esc_nxt        = 1'b0;
            end else begin
              tx_pos_nxt = pos;
              crc_nxt    = crc_new;
            end
          end
        end
        ACT_RX: begin
          if (awaiting_r) begin
            if (!esc_r && data_byte == ESC_MARK) begin
              esc_nxt = 1'b1;
            end else begin
              esc_nxt = 1'b0;
              if (rx_pos_r == 2'd1) begin
                got_first_nxt = data_byte;
              end else if (rx_pos_r == 2'd2) begin
                got_second_nxt = data_byte;
              end
              if (rx_pos_r != POS_MAX) begin
                rx_pos_nxt = rx_pos_r + 2'd1;
              end
              push     = 1'b1;
              job.kind = JOB_RX_BYTE;
              job.data = data_byte;
              job.fin  = ends;
              if (ends) begin
                awaiting_nxt = 1'b0;
                job.status   = (rx_pos_nxt == POS_MAX &&
                                got_first_nxt == sent_first_r &&
                                got_second_nxt == sent_second_r) ? ST_OK : ST_MISMATCH;
              end
            end
          end
        end
        ACT_TICK: begin
          if (awaiting_r) begin
            wait_nxt = ticks;
            if (ticks >= limit_r) begin
              awaiting_nxt = 1'b0;
              esc_nxt      = 1'b0;
              push         = 1'b1;
              job.kind     = JOB_TIMEOUT;
            end
          end
        end
        default: begin
          // unused action code: drop
        end
      endcase
    end
  end

  // Hold link state and the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= TIMEOUT_RESET;
      crc_r         <= CRC_START;
      tx_pos_r      <= '0;
      sent_first_r  <= '0;
      sent_second_r <= '0;
      rx_pos_r      <= '0;
      got_first_r   <= '0;
      got_second_r  <= '0;
      esc_r         <= 1'b0;
      awaiting_r    <= 1'b0;
      wait_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      crc_r         <= crc_nxt;
      tx_pos_r      <= tx_pos_nxt;
      sent_first_r  <= sent_first_nxt;
      sent_second_r <= sent_second_nxt;
      rx_pos_r      <= rx_pos_nxt;
      got_first_r   <= got_first_nxt;
      got_second_r  <= got_second_nxt;
      esc_r         <= esc_nxt;
      awaiting_r    <= awaiting_nxt;
      wait_r        <= wait_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/crcl_queue.sv
`default_nettype none

module crcl_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire crcl_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output crcl_pkg::job_t      head_job
);
  import crcl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/crcl_back.sv
`default_nettype none

module crcl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire crcl_pkg::job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                out_end_of_run,
  output logic [1:0]          out_status
);
  import crcl_pkg::*;

  logic [1:0] beat_r;
  logic       valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic       end_r;
  status_t    status_r;

  kind_t      b_kind;
  logic [7:0] b_byte;
  logic       b_end;
  status_t    b_status;
  logic       b_final;
  logic       load;

  // Expand the head job into the current beat
  always_comb begin
    b_kind   = KIND_TX;
    b_byte   = head_job.data;
    b_end    = 1'b0;
    b_status = ST_NONE;
    b_final  = 1'b1;
    unique case (head_job.kind)
      JOB_TX_BYTE: begin
        b_kind = KIND_TX;
      end
      JOB_TX_FRAME: begin
        b_final = (beat_r == 2'd3);
        unique case (beat_r)
          2'd0: b_byte = head_job.data;
          2'd1: b_byte = head_job.crc[7:0];
          2'd2: b_byte = head_job.crc[15:8];
          default: begin
            b_byte = END_MARK;
            b_end  = 1'b1;
          end
        endcase
      end
      JOB_RX_BYTE: begin
        b_kind   = KIND_RX;
        b_end    = head_job.fin;
        b_status = head_job.status;
      end
      default: begin
        b_kind   = KIND_STATUS;
        b_byte   = '0;
        b_end    = 1'b1;
        b_status = ST_TIMEOUT;
      end
    endcase
  end

  assign load = !valid_r || !out_stall;
  assign pop  = load && head_valid && b_final;

  // Output register: refill whenever it is empty or the current beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= head_valid;
      if (head_valid) begin
        beat_r <= b_final ? 2'd0 : beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind_r   <= b_kind;
      byte_r   <= b_byte;
      end_r    <= b_end;
      status_r <= b_status;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_byte       = byte_r;
  assign out_end_of_run = end_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

>>> rtl/crcl_checker.sv
`default_nettype none

module crcl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_end_of_run,
  input wire logic [1:0] out_status
);
  import crcl_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_end_of_run) && $stable(out_status))
    else $error("stalled result beat changed");

  // Reset empties both sides
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("link not idle after reset");

  // After a frame trailer no transmit beat follows directly
  a_after_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == KIND_TX && out_end_of_run
      |=> !out_valid || out_kind != KIND_TX)
    else $error("transmit beat while reply pending");

  // After a reply end or timeout only transmit beats can follow directly
  a_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_end_of_run
      && (out_kind == KIND_RX || out_kind == KIND_STATUS)
      |=> !out_valid || out_kind == KIND_TX)
    else $error("reply beat after reply ended");

endmodule

bind crc_framed_command_link_core crcl_checker u_crcl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_end_of_run (out_end_of_run),
  .out_status     (out_status)
);

`default_nettype wire
